### rtl/eipx_pkg.sv
package eipx_pkg;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int ENCAP_W  = 2;

  // Link kinds, as written through the configuration port
  localparam logic [KIND_W-1:0] LINK_LOOP = 2'd0;
  localparam logic [KIND_W-1:0] LINK_ETH  = 2'd1;

  // One result transaction
  typedef struct packed {
    logic [BYTE_W-1:0]   payload_byte;
    logic                payload_valid;
    logic                frame_done;
    logic [STATUS_W-1:0] frame_status;
    logic [ENCAP_W-1:0]  encapsulation;
  } eipx_res_t;

endpackage

### rtl/eipx_if.sv
// Input channel: one frame byte per transaction
interface eipx_in_if;
  logic                        valid;
  logic                        ready;
  logic [eipx_pkg::BYTE_W-1:0] frame_byte;
  logic                        frame_end;

  modport source (output valid, output frame_byte, output frame_end, input ready);
  modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

// Result channel
interface eipx_out_if;
  logic                          valid;
  logic                          ready;
  logic [eipx_pkg::BYTE_W-1:0]   payload_byte;
  logic                          payload_valid;
  logic                          frame_done;
  logic [eipx_pkg::STATUS_W-1:0] frame_status;
  logic [eipx_pkg::ENCAP_W-1:0]  encapsulation;

  modport source (output valid, output payload_byte, output payload_valid,
                  output frame_done, output frame_status, output encapsulation,
                  input ready);
  modport sink   (input valid, input payload_byte, input payload_valid,
                  input frame_done, input frame_status, input encapsulation,
                  output ready);
endinterface

// Configuration write channel: link kind register
interface eipx_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [eipx_pkg::KIND_W-1:0] link_kind;

  modport source (output valid, output link_kind, input ready);
  modport sink   (input valid, input link_kind, output ready);
endinterface

### rtl/ethernet_frame_ip_extractor_top.sv
// Each result is registered in the output stage (main or skid register) before it appears on out_ch.
// Throughput: one frame byte per cycle; a two-entry output stage keeps in_ch.ready high
// while a single result waits, so input stalls only when two results are held.
// Reset: synchronous, active-low rst_n clears the parse state and the output stage,
// and sets the link kind register to Ethernet. cfg_ch is always ready.
module ethernet_frame_ip_extractor_top (
  input  logic       clk,
  input  logic       rst_n,
  eipx_in_if.sink    in_ch,
  eipx_out_if.source out_ch,
  eipx_cfg_if.sink   cfg_ch
);

  logic [eipx_pkg::KIND_W-1:0] link_kind_r;
  logic                        in_ready;
  logic                        acc;
  logic                        res_emit;
  eipx_pkg::eipx_res_t         res;

  // Link kind register
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_kind_r <= eipx_pkg::LINK_ETH;
    end else if (cfg_ch.valid) begin
      link_kind_r <= cfg_ch.link_kind;
    end
  end

  // Input transaction
  assign in_ch.ready = in_ready;
  assign acc         = in_ch.valid && in_ready;

  eipx_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .frame_byte (in_ch.frame_byte),
    .frame_end  (in_ch.frame_end),
    .link_kind  (link_kind_r),
    .res_emit   (res_emit),
    .res        (res)
  );

  eipx_out u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (res_emit),
    .res      (res),
    .in_ready (in_ready),
    .out_ch   (out_ch)
  );

endmodule

### rtl/eipx_parse.sv
module eipx_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          acc,
  input  logic [eipx_pkg::BYTE_W-1:0]   frame_byte,
  input  logic                          frame_end,
  input  logic [eipx_pkg::KIND_W-1:0]   link_kind,
  output logic                          res_emit,
  output eipx_pkg::eipx_res_t           res
);

  // Parse phases
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_FORWARD = 2'd1;
  localparam logic [1:0] PH_REJECT  = 2'd2;
  localparam logic [1:0] PH_BADLINK = 2'd3;

  // Frame status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BADLINK   = 2'd1;
  localparam logic [1:0] ST_NOT_IP    = 2'd2;
  localparam logic [1:0] ST_TRUNCATED = 2'd3;

  // Encapsulation codes
  localparam logic [1:0] ENC_LOOP = 2'd0;
  localparam logic [1:0] ENC_ETH2 = 2'd1;
  localparam logic [1:0] ENC_SNAP = 2'd2;
  localparam logic [1:0] ENC_LLC  = 2'd3;

  // Header offsets
  localparam logic [4:0] OFF_TYPE_HI  = 5'd12;
  localparam logic [4:0] OFF_TYPE_LO  = 5'd13;
  localparam logic [4:0] OFF_DSAP     = 5'd14;
  localparam logic [4:0] OFF_SSAP     = 5'd15;
  localparam logic [4:0] OFF_SNAP_HI  = 5'd20;
  localparam logic [4:0] OFF_SNAP_LO  = 5'd21;
  localparam logic [4:0] START_LOOP   = 5'd4;
  localparam logic [4:0] START_ETH2   = 5'd14;
  localparam logic [4:0] START_LLC    = 5'd17;
  localparam logic [4:0] START_SNAP   = 5'd22;
  localparam logic [4:0] POS_LIMIT    = 5'd22;

  // Field values
  localparam logic [15:0] TYPE_IPV4  = 16'h0800;
  localparam logic [15:0] TYPE_IPV6  = 16'h86DD;
  localparam logic [15:0] SNAP_MARK  = 16'hAAAA;
  localparam logic [15:0] MAX_LENGTH = 16'd1500;
  localparam logic [7:0]  SAP_IP     = 8'h06;

  logic [4:0] pos_r,     pos_nxt;
  logic [7:0] type_hi_r, type_hi_nxt;
  logic [7:0] llc_r,     llc_nxt;
  logic [1:0] phase_r,   phase_nxt;
  logic [4:0] start_r,   start_nxt;
  logic [1:0] encap_r,   encap_nxt;

  logic [15:0] type_word;
  logic        is_ip;
  logic        fwd;
  logic [1:0]  status;
  logic [1:0]  encap_out;

  // Decode one byte against the held header state
  always_comb begin
    type_hi_nxt = type_hi_r;
    llc_nxt     = llc_r;
    phase_nxt   = phase_r;
    start_nxt   = start_r;
    encap_nxt   = encap_r;
    pos_nxt     = pos_r;
    status      = ST_OK;

    // Start of frame: sample the link kind
    if (pos_r == 5'd0) begin
      type_hi_nxt = '0;
      llc_nxt     = '0;
      if (link_kind == eipx_pkg::LINK_LOOP) begin
        encap_nxt = ENC_LOOP;
        phase_nxt = PH_FORWARD;
        start_nxt = START_LOOP;
      end else if (link_kind == eipx_pkg::LINK_ETH) begin
        encap_nxt = ENC_ETH2;
        phase_nxt = PH_HEADER;
        start_nxt = START_ETH2;
      end else begin
        encap_nxt = ENC_LOOP;
        phase_nxt = PH_BADLINK;
        start_nxt = '0;
      end
    end

    type_word = {type_hi_nxt, frame_byte};
    is_ip     = (type_word == TYPE_IPV4) || (type_word == TYPE_IPV6);

    // Ethernet header decisions
    if (phase_nxt == PH_HEADER) begin
      case (pos_r)
        OFF_TYPE_HI, OFF_SNAP_HI: begin
          type_hi_nxt = frame_byte;
        end
        OFF_TYPE_LO: begin
          if (type_word > MAX_LENGTH) begin
            if (is_ip) begin
              phase_nxt = PH_FORWARD;
              start_nxt = START_ETH2;
            end else begin
              phase_nxt = PH_REJECT;
            end
          end else begin
            encap_nxt = ENC_LLC;
          end
        end
        OFF_DSAP: begin
          llc_nxt = frame_byte;
          if (frame_byte == SAP_IP) begin
            phase_nxt = PH_FORWARD;
            start_nxt = START_LLC;
          end else if (frame_byte != SNAP_MARK[7:0]) begin
            phase_nxt = PH_REJECT;
          end
        end
        OFF_SSAP: begin
          if ({llc_nxt, frame_byte} == SNAP_MARK) begin
            encap_nxt = ENC_SNAP;
          end else begin
            phase_nxt = PH_REJECT;
          end
        end
        OFF_SNAP_LO: begin
          if (is_ip) begin
            phase_nxt = PH_FORWARD;
            start_nxt = START_SNAP;
          end else begin
            phase_nxt = PH_REJECT;
          end
        end
        default: begin
        end
      endcase
    end

    fwd       = (phase_nxt == PH_FORWARD) && (pos_r >= start_nxt);
    encap_out = encap_nxt;

    // Close the frame or advance the position
    if (frame_end) begin
      case (phase_nxt)
        PH_BADLINK: status = ST_BADLINK;
        PH_REJECT:  status = ST_NOT_IP;
        PH_FORWARD: status = (5'(pos_r + 5'd1) < start_nxt) ? ST_TRUNCATED : ST_OK;
        default:    status = ST_TRUNCATED;
      endcase
      pos_nxt     = '0;
      type_hi_nxt = '0;
      llc_nxt     = '0;
      phase_nxt   = PH_HEADER;
      start_nxt   = '0;
      encap_nxt   = ENC_LOOP;
    end else begin
      pos_nxt = (pos_r < POS_LIMIT) ? 5'(pos_r + 5'd1) : POS_LIMIT;
    end
  end

  // Build the result
  always_comb begin
    res.payload_byte  = fwd ? frame_byte : '0;
    res.payload_valid = fwd;
    res.frame_done    = frame_end;
    res.frame_status  = status;
    res.encapsulation = encap_out;
  end

  assign res_emit = acc && (fwd || frame_end);

  // Hold parse state; advance on each accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      type_hi_r <= '0;
      llc_r     <= '0;
      phase_r   <= PH_HEADER;
      start_r   <= '0;
      encap_r   <= ENC_LOOP;
    end else if (acc) begin
      pos_r     <= pos_nxt;
      type_hi_r <= type_hi_nxt;
      llc_r     <= llc_nxt;
      phase_r   <= phase_nxt;
      start_r   <= start_nxt;
      encap_r   <= encap_nxt;
    end
  end

  a_pos_limit : assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_LIMIT)
    else $error("byte position beyond saturation limit");

  a_end_clears : assert property (@(posedge clk) disable iff (!rst_n)
    (acc && frame_end) |=> (pos_r == 5'd0 && phase_r == PH_HEADER))
    else $error("frame end did not clear parse state");

  a_status_on_done : assert property (@(posedge clk) disable iff (!rst_n)
    (res_emit && res.frame_status != ST_OK) |-> res.frame_done)
    else $error("nonzero status outside frame end");

  a_emit_reason : assert property (@(posedge clk) disable iff (!rst_n)
    res_emit |-> (res.payload_valid || res.frame_done))
    else $error("result emitted without payload or frame end");

endmodule

### rtl/eipx_out.sv
module eipx_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  eipx_pkg::eipx_res_t res,
  output logic                in_ready,
  eipx_out_if.source          out_ch
);

  eipx_pkg::eipx_res_t main_r, main_nxt;
  eipx_pkg::eipx_res_t skid_r, skid_nxt;
  logic                main_valid_r, main_valid_nxt;
  logic                skid_valid_r, skid_valid_nxt;
  logic                pop;

  assign pop      = main_valid_r && out_ch.ready;
  assign in_ready = !skid_valid_r;

  // Refill the output register from the skid stage, then take the new result
  always_comb begin
    main_nxt       = main_r;
    skid_nxt       = skid_r;
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (pop) begin
      if (skid_valid_r) begin
        main_nxt       = skid_r;
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = 1'b0;
      end
    end
    if (push) begin
      if (!main_valid_nxt) begin
        main_nxt       = res;
        main_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers carry no reset
  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid         = main_valid_r;
  assign out_ch.payload_byte  = main_r.payload_byte;
  assign out_ch.payload_valid = main_r.payload_valid;
  assign out_ch.frame_done    = main_r.frame_done;
  assign out_ch.frame_status  = main_r.frame_status;
  assign out_ch.encapsulation = main_r.encapsulation;

  a_skid_behind_main : assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid stage holds a result while output register is empty");

  a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && !pop) |-> !push)
    else $error("result pushed into a full output stage");

  a_hold_on_stall : assert property (@(posedge clk) disable iff (!rst_n)
    (main_valid_r && !out_ch.ready) |=> (main_valid_r && $stable(main_r)))
    else $error("waiting result changed before it was taken");

endmodule

### tb/sv/eipx_payload_checker.sv
// Watches the byte, result and link-kind channels, predicts every result transaction
// and compares it against what the extractor delivers.
module eipx_payload_checker (
  input  logic        clk,
  input  logic        rst_n,
  eipx_in_if          in_ch,
  eipx_out_if         out_ch,
  eipx_cfg_if         cfg_ch,
  output int unsigned fail_count,
  output int unsigned pending_results
);

  localparam logic [15:0] TYPE_IPV4     = 16'h0800;
  localparam logic [15:0] TYPE_IPV6     = 16'h86DD;
  localparam logic [15:0] SNAP_MARK     = 16'hAAAA;
  localparam logic [15:0] MAX_LEN_FIELD = 16'd1500;
  localparam logic [7:0]  SAP_IP        = 8'h06;
  localparam logic [4:0]  LOOP_START    = 5'd4;
  localparam logic [4:0]  ETH2_START    = 5'd14;
  localparam logic [4:0]  LLC_START     = 5'd17;
  localparam logic [4:0]  SNAP_START    = 5'd22;
  localparam logic [4:0]  POS_LIMIT     = 5'd22;
  localparam int unsigned PRINT_LIMIT   = 40;

  typedef enum logic [2:0] {PH_HEADER, PH_FORWARD, PH_REJECT, PH_BADLINK} parse_phase_e;
  typedef enum logic [eipx_pkg::STATUS_W-1:0] {
    ST_FORWARDED, ST_BAD_LINK, ST_NOT_IP, ST_TRUNCATED
  } frame_status_e;
  typedef enum logic [eipx_pkg::ENCAP_W-1:0] {ENC_LOOP, ENC_ETH2, ENC_SNAP, ENC_LLC} encap_e;

  // Shadow of the parser state and of the link kind register
  logic [eipx_pkg::KIND_W-1:0] link_kind;
  logic [4:0]                  frame_pos;
  logic [7:0]                  held_type_hi;
  logic [7:0]                  held_llc;
  parse_phase_e                phase;
  logic [4:0]                  payload_from;
  encap_e                      held_encap;

  eipx_pkg::eipx_res_t expected_payload_q[$];
  int unsigned         result_count;

  function automatic logic is_ip_type(input logic [15:0] word);
    return word == TYPE_IPV4 || word == TYPE_IPV6;
  endfunction

  function automatic void clear_frame_state();
    frame_pos    = '0;
    held_type_hi = '0;
    held_llc     = '0;
    phase        = PH_HEADER;
    payload_from = '0;
    held_encap   = ENC_LOOP;
  endfunction

  function automatic void forward_from(input logic [4:0] start);
    phase        = PH_FORWARD;
    payload_from = start;
  endfunction

  // Advance the parser by one byte; return 1 when the byte yields a result
  function automatic logic predict_payload(input logic [eipx_pkg::BYTE_W-1:0] b,
                                           input logic last,
                                           output eipx_pkg::eipx_res_t res);
    logic [4:0]    pos;
    logic [15:0]   word;
    logic          fwd;
    frame_status_e status;
    pos = frame_pos;

    // Sample the link kind at the first byte of a frame
    if (pos == 5'd0) begin
      held_type_hi = '0;
      held_llc     = '0;
      case (link_kind)
        eipx_pkg::LINK_LOOP: begin
          held_encap = ENC_LOOP;
          forward_from(LOOP_START);
        end
        eipx_pkg::LINK_ETH: begin
          held_encap   = ENC_ETH2;
          phase        = PH_HEADER;
          payload_from = ETH2_START;
        end
        default: begin
          held_encap   = ENC_LOOP;
          phase        = PH_BADLINK;
          payload_from = '0;
        end
      endcase
    end

    // Decode the type / length field and the LLC / SNAP header
    word = {held_type_hi, b};
    if (phase == PH_HEADER) begin
      case (pos)
        5'd12, 5'd20: held_type_hi = b;
        5'd13: begin
          if (word > MAX_LEN_FIELD) begin
            if (is_ip_type(word)) forward_from(ETH2_START);
            else phase = PH_REJECT;
          end else begin
            held_encap = ENC_LLC;
          end
        end
        5'd14: begin
          held_llc = b;
          if (b == SAP_IP) forward_from(LLC_START);
          else if (b != SNAP_MARK[7:0]) phase = PH_REJECT;
        end
        5'd15: begin
          if ({held_llc, b} == SNAP_MARK) held_encap = ENC_SNAP;
          else phase = PH_REJECT;
        end
        5'd21: begin
          if (is_ip_type(word)) forward_from(SNAP_START);
          else phase = PH_REJECT;
        end
        default: ;
      endcase
    end

    fwd    = (phase == PH_FORWARD) && (pos >= payload_from);
    status = ST_FORWARDED;
    if (last) begin
      case (phase)
        PH_BADLINK: status = ST_BAD_LINK;
        PH_REJECT:  status = ST_NOT_IP;
        PH_FORWARD: status = (int'(pos) + 1 < int'(payload_from)) ? ST_TRUNCATED : ST_FORWARDED;
        default:    status = ST_TRUNCATED;
      endcase
    end

    res.payload_byte  = fwd ? b : '0;
    res.payload_valid = fwd;
    res.frame_done    = last;
    res.frame_status  = status;
    res.encapsulation = held_encap;

    // Drop all frame state at the frame end, else advance with saturation
    if (last) clear_frame_state();
    else frame_pos = (pos < POS_LIMIT) ? pos + 5'd1 : POS_LIMIT;

    return fwd || last;
  endfunction

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_LIMIT) $display("[checker] result %0d: %s", result_count, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Compare the delivered transaction, then predict from the accepted byte
  always @(posedge clk) begin
    eipx_pkg::eipx_res_t want;
    eipx_pkg::eipx_res_t pred;
    if (!rst_n) begin
      clear_frame_state();
      link_kind = eipx_pkg::LINK_ETH;
      expected_payload_q.delete();
      fail_count   = 0;
      result_count = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_payload_q.size() == 0) begin
          report_mismatch("result transaction with nothing expected");
        end else begin
          want = expected_payload_q.pop_front();
          check_field("payload_byte", out_ch.payload_byte, want.payload_byte);
          check_field("payload_valid", 8'(out_ch.payload_valid), 8'(want.payload_valid));
          check_field("frame_done", 8'(out_ch.frame_done), 8'(want.frame_done));
          check_field("frame_status", 8'(out_ch.frame_status), 8'(want.frame_status));
          check_field("encapsulation", 8'(out_ch.encapsulation), 8'(want.encapsulation));
        end
        result_count++;
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_payload(in_ch.frame_byte, in_ch.frame_end, pred))
          expected_payload_q.push_back(pred);
      end
      if (cfg_ch.valid && cfg_ch.ready) link_kind = cfg_ch.link_kind;
    end
    pending_results = expected_payload_q.size();
  end

endmodule

### tb/sv/tb_ethernet_frame_ip_extractor_top.sv
module tb_ethernet_frame_ip_extractor_top;

  localparam logic [eipx_pkg::KIND_W-1:0] LINK_UNSUP_LO = 2'd2;
  localparam logic [eipx_pkg::KIND_W-1:0] LINK_UNSUP_HI = 2'd3;
  localparam logic [15:0] TYPE_IPV4      = 16'h0800;
  localparam logic [15:0] TYPE_IPV6      = 16'h86DD;
  localparam logic [7:0]  SNAP_BYTE      = 8'hAA;
  localparam logic [7:0]  SAP_IP         = 8'h06;
  localparam int unsigned MAX_LEN_FIELD  = 1500;
  localparam int unsigned IDLE_PCT       = 7;
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  typedef enum int {
    SH_IPV4, SH_IPV6, SH_SNAP_IP, SH_LLC_IP,
    SH_ETH_OTHER, SH_SNAP_OTHER, SH_LLC_OTHER, SH_SNAP_BROKEN, SH_NOISE
  } frame_shape_e;

  typedef struct packed {
    logic [eipx_pkg::BYTE_W-1:0] frame_byte;
    logic                        frame_end;
  } frame_item_t;

  typedef logic [7:0] byte_q_t[$];

  logic clk;
  logic rst_n;

  eipx_in_if  in_ch();
  eipx_out_if out_ch();
  eipx_cfg_if cfg_ch();

  int unsigned fail_count;
  int unsigned pending_results;

  frame_item_t byte_stream_q[$];
  int unsigned queued_items = 0;
  int unsigned src_idle_pct = IDLE_PCT;
  int unsigned sink_idle_pct = IDLE_PCT;
  bit          hold_off_req = 1'b0;
  bit          hold_off_taken = 1'b0;

  ethernet_frame_ip_extractor_top DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  eipx_payload_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .cfg_ch          (cfg_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Offer queued frame bytes, idling at random between transactions
  initial begin : byte_sender
    frame_item_t item;
    in_ch.valid      <= 1'b0;
    in_ch.frame_byte <= '0;
    in_ch.frame_end  <= 1'b0;
    forever begin
      @(posedge clk);
      if (!in_ch.valid || in_ch.ready) begin
        if (rst_n && byte_stream_q.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
          item = byte_stream_q.pop_front();
          in_ch.valid      <= 1'b1;
          in_ch.frame_byte <= item.frame_byte;
          in_ch.frame_end  <= item.frame_end;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Accept results; hold off once for a long stretch when asked
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        hold_left      = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // End the run when no transaction moves for too long
  initial begin : watchdog
    int unsigned stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("[ethernet_frame_ip_extractor_top] ERROR");
    $finish;
  end

  function automatic void push_byte(input logic [7:0] b, input logic last);
    frame_item_t item;
    item.frame_byte = b;
    item.frame_end  = last;
    byte_stream_q.push_back(item);
    queued_items++;
  endfunction

  function automatic void queue_frame(input byte_q_t fr);
    foreach (fr[i]) push_byte(fr[i], i == fr.size() - 1);
  endfunction

  function automatic void queue_random_frame(input int unsigned max_len);
    byte_q_t     fr;
    int unsigned len;
    len = $urandom_range(max_len, 1);
    repeat (len) fr.push_back(8'($urandom));
    queue_frame(fr);
  endfunction

  function automatic logic [15:0] pick_non_ip_word(input logic above_length);
    logic [15:0] word;
    do begin
      case ($urandom_range(3))
        0:       word = above_length ? 16'(MAX_LEN_FIELD + 1) : 16'h0000;
        1:       word = 16'hFFFF;
        2:       word = TYPE_IPV6 ^ 16'h0001;
        default: word = 16'($urandom);
      endcase
    end while (word == TYPE_IPV4 || word == TYPE_IPV6 ||
               (above_length && word <= MAX_LEN_FIELD));
    return word;
  endfunction

  function automatic logic [15:0] pick_length_word();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'(MAX_LEN_FIELD);
      default: return 16'($urandom_range(MAX_LEN_FIELD));
    endcase
  endfunction

  function automatic frame_shape_e pick_shape();
    if ($urandom_range(99) < 70) begin
      case ($urandom_range(3))
        0:       return SH_IPV4;
        1:       return SH_IPV6;
        2:       return SH_SNAP_IP;
        default: return SH_LLC_IP;
      endcase
    end
    case ($urandom_range(4))
      0:       return SH_ETH_OTHER;
      1:       return SH_SNAP_OTHER;
      2:       return SH_LLC_OTHER;
      3:       return SH_SNAP_BROKEN;
      default: return SH_NOISE;
    endcase
  endfunction

  // Build an Ethernet frame of the given shape, sometimes cut short or header-only
  function automatic void queue_eth_frame(input frame_shape_e shape);
    byte_q_t     fr;
    logic [15:0] word;
    logic [7:0]  b;
    int unsigned hdr_len;
    int unsigned total;
    for (int i = 0; i < 12; i++) fr.push_back(8'($urandom));
    hdr_len = 14;
    case (shape)
      SH_IPV4, SH_IPV6: begin
        word = (shape == SH_IPV4) ? TYPE_IPV4 : TYPE_IPV6;
        fr.push_back(word[15:8]);
        fr.push_back(word[7:0]);
      end
      SH_ETH_OTHER: begin
        word = pick_non_ip_word(1'b1);
        fr.push_back(word[15:8]);
        fr.push_back(word[7:0]);
      end
      SH_NOISE: ;
      default: begin
        word = pick_length_word();
        fr.push_back(word[15:8]);
        fr.push_back(word[7:0]);
        case (shape)
          SH_LLC_IP: begin
            fr.push_back(SAP_IP);
            hdr_len = 17;
          end
          SH_LLC_OTHER: begin
            do b = 8'($urandom); while (b == SAP_IP || b == SNAP_BYTE);
            fr.push_back(b);
            hdr_len = 15;
          end
          SH_SNAP_BROKEN: begin
            do b = 8'($urandom); while (b == SNAP_BYTE);
            fr.push_back(SNAP_BYTE);
            fr.push_back(b);
            hdr_len = 16;
          end
          default: begin
            fr.push_back(SNAP_BYTE);
            fr.push_back(SNAP_BYTE);
            repeat (4) fr.push_back(8'($urandom));
            if (shape == SH_SNAP_IP) word = $urandom_range(1) ? TYPE_IPV4 : TYPE_IPV6;
            else word = pick_non_ip_word(1'b0);
            fr.push_back(word[15:8]);
            fr.push_back(word[7:0]);
            hdr_len = 22;
          end
        endcase
      end
    endcase

    // Choose a truncated, header-only or full-length frame
    case ($urandom_range(9))
      0, 1:    total = $urandom_range(hdr_len - 1, 1);
      2:       total = hdr_len;
      3:       total = hdr_len + $urandom_range(40, 21);
      default: total = hdr_len + $urandom_range(20, 1);
    endcase
    while (fr.size() < total) fr.push_back(8'($urandom));
    while (fr.size() > total) void'(fr.pop_back());
    queue_frame(fr);
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    while (byte_stream_q.size() > 0 || in_ch.valid || pending_results > 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_link_kind(input logic [eipx_pkg::KIND_W-1:0] kind);
    @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.link_kind <= kind;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Reconfigure once idle, then queue frames until the byte budget is reached
  task automatic run_phase(input logic [eipx_pkg::KIND_W-1:0] kind,
                           input int unsigned budget);
    int unsigned first;
    wait_drained();
    write_link_kind(kind);
    first = queued_items;
    while (queued_items - first < budget) begin
      if (kind == eipx_pkg::LINK_ETH) queue_eth_frame(pick_shape());
      else if (kind == eipx_pkg::LINK_LOOP) queue_random_frame(30);
      else queue_random_frame(8);
    end
  endtask

  initial begin : stimulus
    rst_n            <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.link_kind <= eipx_pkg::LINK_ETH;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Ethernet after reset: frame cut before the type, then a header-only IPv4 frame
    push_byte(8'hFF, 1'b1);
    for (int i = 0; i < 12; i++) push_byte((i < 6) ? 8'h00 : 8'hFF, 1'b0);
    push_byte(TYPE_IPV4[15:8], 1'b0);
    push_byte(TYPE_IPV4[7:0], 1'b1);

    // Loopback: extreme payload bytes, then a frame inside the header
    wait_drained();
    write_link_kind(eipx_pkg::LINK_LOOP);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h5A, 1'b0);
    push_byte(8'hA5, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7E, 1'b1);

    // Unsupported link kind
    wait_drained();
    write_link_kind(LINK_UNSUP_HI);
    push_byte(8'h80, 1'b1);

    // Random frames across link kinds
    run_phase(eipx_pkg::LINK_ETH, 400);
    run_phase(eipx_pkg::LINK_LOOP, 220);
    hold_off_req = 1'b1;

    wait_drained();
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    run_phase(eipx_pkg::LINK_ETH, 350);
    wait_drained();
    src_idle_pct  = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;

    run_phase(LINK_UNSUP_LO, 40);
    run_phase(eipx_pkg::LINK_ETH, 300);
    run_phase(LINK_UNSUP_HI, 40);
    run_phase(eipx_pkg::LINK_LOOP, 100);
    run_phase(eipx_pkg::LINK_ETH, 250);
    wait_drained();

    if (fail_count == 0) $display("[ethernet_frame_ip_extractor_top] OK");
    else $display("[ethernet_frame_ip_extractor_top] ERROR");
    $finish;
  end

endmodule
